// ===== design/ssmf_pkg.sv =====
// shared types, constants and digit helpers for the seven-segment formatter
package ssmf_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int DIGIT_W     = 4;
    localparam int VALUE_W     = 8;
    localparam int SCAN_W      = 2;
    localparam int PAIR_W      = 7;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        FUNC_REFRESH   = 2'd0,
        FUNC_SET_MUSIC = 2'd1,
        FUNC_SET_GAME  = 2'd2,
        FUNC_SET_TIME  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_MUSIC = 2'd1,
        MODE_GAME  = 2'd2,
        MODE_TIME  = 2'd3
    } t_mode;

    // register index of display_mode, decoded from paddr word bit
    localparam logic REG_DISPLAY_MODE = 1'b0;

    localparam logic [VALUE_W-1:0] SINGLE_MAX = 8'd9;
    localparam logic [VALUE_W-1:0] SIXTY_MAX  = 8'd59;
    localparam logic [VALUE_W-1:0] SCORE_MAX  = 8'd99;
    localparam logic [VALUE_W-1:0] HOUR_MAX   = 8'd23;

    // tens = (v * 103) >> 10, exact for v up to 99
    localparam logic [PAIR_W-1:0] TENS_RECIP = 7'd103;
    localparam int                TENS_SHIFT = 10;
    localparam int                PROD_W     = 2 * PAIR_W;

    localparam logic [DIGIT_W-1:0] SELECT_NONE = 4'hF;

    typedef logic [DIGIT_W-1:0]               t_digit;
    typedef t_digit [DIGIT_COUNT-1:0]         t_digits;

    typedef struct packed {
        logic    load;
        t_digits digits;
    } t_buf_load;

    typedef struct packed {
        t_digit             bcd_value;
        logic               decimal_point;
        logic [DIGIT_W-1:0] digit_select_n;
    } t_result;

    function automatic logic [VALUE_W-1:0] clamp_to(input logic [VALUE_W-1:0] v,
                                                    input logic [VALUE_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    // split a value below 100 into {tens, units}
    function automatic logic [2*DIGIT_W-1:0] split_pair(input logic [PAIR_W-1:0] v);
        logic [PROD_W-1:0]  prod;
        logic [DIGIT_W-1:0] tens;
        logic [PAIR_W-1:0]  tens_x10;
        logic [PAIR_W-1:0]  units;
        prod     = PROD_W'(v) * PROD_W'(TENS_RECIP);
        tens     = prod[TENS_SHIFT +: DIGIT_W];
        tens_x10 = PAIR_W'({tens, 3'b000}) + PAIR_W'({tens, 1'b0});
        units    = v - tens_x10;
        return {tens, units[DIGIT_W-1:0]};
    endfunction

endpackage

// ===== design/ssmf_if.sv =====
// valid/ready channel interfaces for input and result transactions

interface ssmf_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     func;
    logic [ssmf_pkg::VALUE_W-1:0]   first_value;
    logic [ssmf_pkg::VALUE_W-1:0]   second_value;
    logic [ssmf_pkg::VALUE_W-1:0]   third_value;

    modport source (output valid, func, first_value, second_value, third_value,
                    input ready);
    modport sink   (input valid, func, first_value, second_value, third_value,
                    output ready);
endinterface

interface ssmf_out_if;
    logic                           valid;
    logic                           ready;
    logic [ssmf_pkg::DIGIT_W-1:0]   bcd_value;
    logic                           decimal_point;
    logic [ssmf_pkg::DIGIT_W-1:0]   digit_select_n;

    modport source (output valid, bcd_value, decimal_point, digit_select_n,
                    input ready);
    modport sink   (input valid, bcd_value, decimal_point, digit_select_n,
                    output ready);
endinterface

// ===== design/ssmf_layout.sv =====
// clamps set values and arranges them into the four-digit buffer layout
module ssmf_layout (
    input  logic [1:0]                   i_func,
    input  logic [ssmf_pkg::VALUE_W-1:0] i_first_value,
    input  logic [ssmf_pkg::VALUE_W-1:0] i_second_value,
    input  logic [ssmf_pkg::VALUE_W-1:0] i_third_value,
    output ssmf_pkg::t_buf_load          o_buf_load
);

    logic [ssmf_pkg::VALUE_W-1:0]   first_clamped;
    logic [ssmf_pkg::VALUE_W-1:0]   second_clamped;
    logic [ssmf_pkg::VALUE_W-1:0]   third_clamped;
    logic [2*ssmf_pkg::DIGIT_W-1:0] first_pair;
    logic [2*ssmf_pkg::DIGIT_W-1:0] second_pair;

    always_comb begin
        first_clamped  = i_first_value;
        second_clamped = i_second_value;
        third_clamped  = ssmf_pkg::clamp_to(i_third_value, ssmf_pkg::SINGLE_MAX);
        case (ssmf_pkg::t_func'(i_func))
            ssmf_pkg::FUNC_SET_MUSIC: begin
                first_clamped  = ssmf_pkg::clamp_to(i_first_value, ssmf_pkg::SINGLE_MAX);
                second_clamped = ssmf_pkg::clamp_to(i_second_value, ssmf_pkg::SIXTY_MAX);
            end
            ssmf_pkg::FUNC_SET_GAME: begin
                first_clamped  = ssmf_pkg::clamp_to(i_first_value, ssmf_pkg::SIXTY_MAX);
                second_clamped = ssmf_pkg::clamp_to(i_second_value, ssmf_pkg::SCORE_MAX);
            end
            default: begin
                first_clamped  = ssmf_pkg::clamp_to(i_first_value, ssmf_pkg::HOUR_MAX);
                second_clamped = ssmf_pkg::clamp_to(i_second_value, ssmf_pkg::SIXTY_MAX);
            end
        endcase
    end

    assign first_pair  = ssmf_pkg::split_pair(first_clamped[ssmf_pkg::PAIR_W-1:0]);
    assign second_pair = ssmf_pkg::split_pair(second_clamped[ssmf_pkg::PAIR_W-1:0]);

    always_comb begin
        o_buf_load.load = (ssmf_pkg::t_func'(i_func) != ssmf_pkg::FUNC_REFRESH);
        if (ssmf_pkg::t_func'(i_func) == ssmf_pkg::FUNC_SET_MUSIC) begin
            // minutes, seconds tens, seconds units, song number
            o_buf_load.digits[0] = first_clamped[ssmf_pkg::DIGIT_W-1:0];
            o_buf_load.digits[1] = second_pair[2*ssmf_pkg::DIGIT_W-1:ssmf_pkg::DIGIT_W];
            o_buf_load.digits[2] = second_pair[ssmf_pkg::DIGIT_W-1:0];
            o_buf_load.digits[3] = third_clamped[ssmf_pkg::DIGIT_W-1:0];
        end else begin
            o_buf_load.digits[0] = first_pair[2*ssmf_pkg::DIGIT_W-1:ssmf_pkg::DIGIT_W];
            o_buf_load.digits[1] = first_pair[ssmf_pkg::DIGIT_W-1:0];
            o_buf_load.digits[2] = second_pair[2*ssmf_pkg::DIGIT_W-1:ssmf_pkg::DIGIT_W];
            o_buf_load.digits[3] = second_pair[ssmf_pkg::DIGIT_W-1:0];
        end
    end

endmodule

// ===== design/seven_segment_mux_formatter.sv =====
// Four-digit multiplexed BCD display formatter. The block accepts one transaction per cycle while
// input ready is high: set transactions (func 1..3) load the digit buffer in the music,
// game or time layout and return nothing; refresh transactions (func 0) return one result for
// the digit under the scan index, which advances on every refresh. A two-entry output stage
// (result register plus skid register) keeps input ready high while one result waits, so the
// input side only stalls when two refresh results are pending. display_mode is written through
// the APB port at byte address 0; reset leaves mode off and the buffer cleared.
module seven_segment_mux_formatter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ssmf_in_if.sink                           i_in,
    ssmf_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ssmf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ssmf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [ssmf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    ssmf_pkg::t_mode                   r_mode;
    ssmf_pkg::t_digits                 r_buf;
    logic [ssmf_pkg::SCAN_W-1:0]       r_scan;
    ssmf_pkg::t_digit                  r_last;
    logic                              r_out_valid;
    ssmf_pkg::t_result                 r_out;
    logic                              r_skid_valid;
    ssmf_pkg::t_result                 r_skid;

    ssmf_pkg::t_buf_load               buf_load;
    ssmf_pkg::t_result                 n_result;
    ssmf_pkg::t_digit                  n_last;
    logic [ssmf_pkg::SCAN_W-1:0]       dp_pos;
    logic                              in_fire;
    logic                              refresh_fire;
    logic                              out_fire;
    logic                              cfg_write;

    ssmf_layout u_layout (
        .i_func         (i_in.func),
        .i_first_value  (i_in.first_value),
        .i_second_value (i_in.second_value),
        .i_third_value  (i_in.third_value),
        .o_buf_load     (buf_load)
    );

    assign pready    = 1'b1;
    assign prdata    = ssmf_pkg::CFG_DATA_W'(r_mode);
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[ssmf_pkg::CFG_ADDR_W-1] == ssmf_pkg::REG_DISPLAY_MODE);

    assign i_in.ready   = !r_skid_valid;
    assign in_fire      = i_in.valid && !r_skid_valid;
    assign refresh_fire = in_fire && !buf_load.load;
    assign out_fire     = r_out_valid && o_out.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.bcd_value      = r_out.bcd_value;
    assign o_out.decimal_point  = r_out.decimal_point;
    assign o_out.digit_select_n = r_out.digit_select_n;

    // result for the digit under the scan index, or a blanked result holding the last value when mode is off
    always_comb begin
        dp_pos = (r_mode == ssmf_pkg::MODE_MUSIC) ? ssmf_pkg::SCAN_W'(0) : ssmf_pkg::SCAN_W'(1);
        if (r_mode == ssmf_pkg::MODE_OFF) begin
            n_last                  = r_last;
            n_result.bcd_value      = r_last;
            n_result.decimal_point  = 1'b0;
            n_result.digit_select_n = ssmf_pkg::SELECT_NONE;
        end else begin
            n_last                  = r_buf[r_scan];
            n_result.bcd_value      = r_buf[r_scan];
            n_result.decimal_point  = (r_scan == dp_pos);
            n_result.digit_select_n = ~(ssmf_pkg::DIGIT_W'(1) << r_scan);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ssmf_pkg::MODE_OFF;
            r_buf        <= '0;
            r_scan       <= '0;
            r_last       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_mode <= ssmf_pkg::t_mode'(pwdata[1:0]);
            end
            if (in_fire && buf_load.load) begin
                r_buf <= buf_load.digits;
            end
            if (refresh_fire) begin
                r_scan <= r_scan + 1'b1;
                r_last <= n_last;
            end
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (!r_out_valid || out_fire) begin
                r_out_valid <= refresh_fire;
                r_out       <= n_result;
            end else if (refresh_fire) begin
                // result register still held downstream, park the new result
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

// ===== bench/tb_seven_segment_mux_formatter.sv =====
// self-checking testbench for the four-digit seven-segment multiplexing formatter
module tb_seven_segment_mux_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 120;
    localparam int REPORT_CAP     = 100;
    localparam logic [ssmf_pkg::CFG_ADDR_W-1:0] MODE_ADDR =
        ssmf_pkg::CFG_ADDR_W'({ssmf_pkg::REG_DISPLAY_MODE, 2'b00});

    // tracks digit buffer, scan position and held bcd lines; queues the expected digits
    class digit_scan_tracker;
        ssmf_pkg::t_mode                 mode;
        ssmf_pkg::t_digit                digits [ssmf_pkg::DIGIT_COUNT];
        logic [ssmf_pkg::SCAN_W-1:0]     scan;
        ssmf_pkg::t_digit                held_bcd;
        ssmf_pkg::t_result               due_digits [$];
        int                              errors;
        int                              checked;
        int                              reports;

        function new();
            mode     = ssmf_pkg::MODE_OFF;
            scan     = '0;
            held_bcd = '0;
            errors   = 0;
            checked  = 0;
            reports  = 0;
            foreach (digits[i]) digits[i] = '0;
        endfunction

        function void set_mode(ssmf_pkg::t_mode m);
            mode = m;
        endfunction

        function logic [ssmf_pkg::VALUE_W-1:0] cap(logic [ssmf_pkg::VALUE_W-1:0] v,
                                                   logic [ssmf_pkg::VALUE_W-1:0] lim);
            return (v > lim) ? lim : v;
        endfunction

        function void put_pair(int pos, logic [ssmf_pkg::VALUE_W-1:0] v);
            digits[pos]     = ssmf_pkg::t_digit'(v / 10);
            digits[pos + 1] = ssmf_pkg::t_digit'(v % 10);
        endfunction

        function void take_item(ssmf_pkg::t_func f, logic [ssmf_pkg::VALUE_W-1:0] a,
                                logic [ssmf_pkg::VALUE_W-1:0] b,
                                logic [ssmf_pkg::VALUE_W-1:0] c);
            ssmf_pkg::t_result           r;
            logic [ssmf_pkg::SCAN_W-1:0] idx;
            logic [ssmf_pkg::SCAN_W-1:0] dp_pos;
            case (f)
                ssmf_pkg::FUNC_SET_MUSIC: begin
                    digits[0] = ssmf_pkg::t_digit'(cap(a, ssmf_pkg::SINGLE_MAX));
                    put_pair(1, cap(b, ssmf_pkg::SIXTY_MAX));
                    digits[3] = ssmf_pkg::t_digit'(cap(c, ssmf_pkg::SINGLE_MAX));
                end
                ssmf_pkg::FUNC_SET_GAME: begin
                    put_pair(0, cap(a, ssmf_pkg::SIXTY_MAX));
                    put_pair(2, cap(b, ssmf_pkg::SCORE_MAX));
                end
                ssmf_pkg::FUNC_SET_TIME: begin
                    put_pair(0, cap(a, ssmf_pkg::HOUR_MAX));
                    put_pair(2, cap(b, ssmf_pkg::SIXTY_MAX));
                end
                default: begin
                    idx  = scan;
                    scan = scan + 1'b1;
                    if (mode == ssmf_pkg::MODE_OFF) begin
                        // blanked: lines hold the last driven value
                        r.bcd_value      = held_bcd;
                        r.decimal_point  = 1'b0;
                        r.digit_select_n = ssmf_pkg::SELECT_NONE;
                    end else begin
                        held_bcd         = digits[idx];
                        dp_pos           = (mode == ssmf_pkg::MODE_MUSIC) ? 2'd0 : 2'd1;
                        r.bcd_value      = held_bcd;
                        r.decimal_point  = (idx == dp_pos);
                        r.digit_select_n = ~(4'b0001 << idx);
                    end
                    due_digits.push_back(r);
                end
            endcase
        endfunction

        function void note_error(string what, int want, int got);
            errors++;
            if (reports < REPORT_CAP)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            else if (reports == REPORT_CAP)
                $display("%0t: further mismatches counted without report", $time);
            reports++;
        endfunction

        function void check_digit(ssmf_pkg::t_result got);
            ssmf_pkg::t_result want;
            if (due_digits.size() == 0) begin
                note_error("unexpected result, bcd_value", -1, got.bcd_value);
                return;
            end
            want = due_digits.pop_front();
            checked++;
            if (got.bcd_value !== want.bcd_value)
                note_error("bcd_value", want.bcd_value, got.bcd_value);
            if (got.decimal_point !== want.decimal_point)
                note_error("decimal_point", want.decimal_point, got.decimal_point);
            if (got.digit_select_n !== want.digit_select_n)
                note_error("digit_select_n", want.digit_select_n, got.digit_select_n);
        endfunction

        function int outstanding();
            return due_digits.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ssmf_pkg::CFG_ADDR_W-1:0] paddr;
    logic [ssmf_pkg::CFG_DATA_W-1:0] pwdata;
    logic [ssmf_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    ssmf_in_if  in_ch ();
    ssmf_out_if out_ch ();

    digit_scan_tracker sb = new();

    bit idle_on = 1'b1;
    int items_sent;
    int mode_writes;
    int idle_cycles = 0;

    seven_segment_mux_formatter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result first, then input: a result accepted this edge belongs to an earlier transaction
    always @(posedge i_clk) begin : monitor
        ssmf_pkg::t_result got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.bcd_value      = out_ch.bcd_value;
                got.decimal_point  = out_ch.decimal_point;
                got.digit_select_n = out_ch.digit_select_n;
                sb.check_digit(got);
            end
            if (in_ch.valid && in_ch.ready)
                sb.take_item(ssmf_pkg::t_func'(in_ch.func), in_ch.first_value,
                             in_ch.second_value, in_ch.third_value);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still due", $time, sb.outstanding());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random stall before each result while idle_on is set
    initial begin : result_sink
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic send_item(ssmf_pkg::t_func f, logic [ssmf_pkg::VALUE_W-1:0] a,
                             logic [ssmf_pkg::VALUE_W-1:0] b,
                             logic [ssmf_pkg::VALUE_W-1:0] c);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.func         = f;
        in_ch.first_value  = a;
        in_ch.second_value = b;
        in_ch.third_value  = c;
        in_ch.valid        = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic refresh(int n);
        repeat (n) send_item(ssmf_pkg::FUNC_REFRESH, '0, '0, '0);
    endtask

    // stop sending, wait for every due result, then let the block settle
    task automatic quiesce(int pad);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (pad) @(posedge i_clk);
    endtask

    task automatic write_mode(ssmf_pkg::t_mode m);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = MODE_ADDR;
        pwdata  = ssmf_pkg::CFG_DATA_W'(m);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_mode(m);
        mode_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [ssmf_pkg::VALUE_W-1:0] pick_value();
        // half in 0..110, just past the largest clamp limit, half over the whole byte
        return $urandom_range(0, 1) ? ssmf_pkg::VALUE_W'($urandom_range(0, 255))
                                    : ssmf_pkg::VALUE_W'($urandom_range(0, 110));
    endfunction

    initial begin : stimulus
        ssmf_pkg::t_mode phase_mode;
        ssmf_pkg::t_func f;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.func         = ssmf_pkg::FUNC_REFRESH;
        in_ch.first_value  = '0;
        in_ch.second_value = '0;
        in_ch.third_value  = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        items_sent         = 0;
        mode_writes        = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: blanking, clamping in every layout, set while off, dp positions
        quiesce(SETTLE_CYCLES);
        write_mode(ssmf_pkg::MODE_OFF);
        refresh(2);
        send_item(ssmf_pkg::FUNC_SET_MUSIC, 8'd255, 8'd255, 8'd255);
        refresh(2);
        quiesce(SETTLE_CYCLES);
        write_mode(ssmf_pkg::MODE_MUSIC);
        refresh(4);
        quiesce(SETTLE_CYCLES);
        write_mode(ssmf_pkg::MODE_OFF);
        refresh(2);
        send_item(ssmf_pkg::FUNC_SET_GAME, 8'd255, 8'd255, 8'd255);
        quiesce(SETTLE_CYCLES);
        write_mode(ssmf_pkg::MODE_GAME);
        refresh(4);
        send_item(ssmf_pkg::FUNC_SET_TIME, 8'd24, 8'd60, 8'd0);
        quiesce(SETTLE_CYCLES);
        write_mode(ssmf_pkg::MODE_TIME);
        refresh(4);
        send_item(ssmf_pkg::FUNC_SET_TIME, 8'd23, 8'd59, 8'd0);
        send_item(ssmf_pkg::FUNC_SET_TIME, 8'd0, 8'd0, 8'd255);
        refresh(2);

        // random phases, each under one display mode
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            phase_mode = (ph < 4) ? ssmf_pkg::t_mode'(ph)
                                  : ssmf_pkg::t_mode'($urandom_range(0, 3));
            quiesce(SETTLE_CYCLES);
            idle_on = (ph % 3 != 2);
            write_mode(phase_mode);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 5 && k == PHASE_ITEMS / 2)
                    quiesce(0);
                f = ($urandom_range(0, 9) < 6) ? ssmf_pkg::FUNC_REFRESH
                                               : ssmf_pkg::t_func'($urandom_range(1, 3));
                send_item(f, pick_value(), pick_value(), pick_value());
            end
        end

        quiesce(SETTLE_CYCLES * 2);
        $display("covered %0d input transactions and %0d checked results over %0d mode writes",
                 items_sent, sb.checked, mode_writes);
        $display("all layouts, blanking, clamp limits and random back-pressure were exercised");
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
design/ssmf_pkg.sv
design/ssmf_if.sv
design/ssmf_layout.sv
design/seven_segment_mux_formatter.sv
bench/tb_seven_segment_mux_formatter.sv
